>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by the journal top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ujc_pkg.sv
// ----------------------------------------------------------------------------
// ujc_pkg
// Types and constants for the undo journal with checkpoints.
// ----------------------------------------------------------------------------
package ujc_pkg;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_CKPT   = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_REVERT = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_CKPT = 2'd2;

    localparam logic [4:0] TAG_CKPT   = 5'd16;
    localparam logic [4:0] TAG_COMMIT = 5'd17;

    // one stored record: tag, id, slot key, prior value
    localparam int REC_W = 5 + 32 + 256 + 256;

    typedef struct packed {
        logic [2:0]   op;
        logic [3:0]   kind;
        logic [31:0]  id;
        logic [255:0] slot;
        logic [255:0] prior;
    } t_cmd;

    typedef struct packed {
        logic [1:0]   status;
        logic         present;
        logic [3:0]   kind;
        logic [31:0]  id;
        logic [255:0] slot;
        logic [63:0]  prior_lo;
        logic [63:0]  prior_mid;
        logic [63:0]  prior_hi;
        logic         last;
    } t_res;

endpackage

>>> sv/ujc_ram.sv
// ----------------------------------------------------------------------------
// ujc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ujc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/ujc_front.sv
// ----------------------------------------------------------------------------
// ujc_front
// Two-entry command queue between the input port and the journal engine.
// ----------------------------------------------------------------------------
module ujc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  ujc_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output ujc_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    import ujc_pkg::*;

    t_cmd       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    // payload storage
    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wr <= ~r_wr;
            if (w_out) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end
endmodule

>>> sv/ujc_back.sv
// ----------------------------------------------------------------------------
// ujc_back
// Journal engine: memory, checkpoint search, revert walk, result register.
// ----------------------------------------------------------------------------
module ujc_back #(
    parameter int JOURNAL_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ujc_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_res_valid,
    output ujc_pkg::t_res o_res,
    input  logic          i_res_pop,
    output logic [$clog2(JOURNAL_DEPTH+1)-1:0] o_count
);
    import ujc_pkg::*;

    localparam int AW = $clog2(JOURNAL_DEPTH);
    localparam int CW = $clog2(JOURNAL_DEPTH + 1);
    localparam int RES_W = $bits(t_res);
    localparam logic [CW-1:0] DEPTH_C = CW'(JOURNAL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SRCH_RD, S_SRCH, S_WALK_RD, S_WALK, S_DONE
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [CW-1:0] r_count, r_idx, r_where;
    logic [CW-1:0] r_closed;
    logic [1:0]    r_status;
    t_res          r_res;
    logic          r_res_valid;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [REC_W-1:0] w_wdata, w_rdata;
    logic [4:0]    w_tag;
    logic          w_slot_free;
    logic [CW-1:0] w_im1;
    logic          w_marker, w_load;

    assign w_slot_free = !r_res_valid || i_res_pop;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_count     = r_count;
    assign w_tag       = w_rdata[REC_W-1 -: 5];
    assign w_im1       = r_idx - 1'b1;
    assign o_take      = (r_state == S_IDLE) && i_valid;
    assign w_marker    = (w_tag == TAG_CKPT) || (w_tag == TAG_COMMIT);
    // a new beat enters the result register this cycle
    assign w_load      = w_slot_free &&
                         ((r_state == S_DONE) || (r_state == S_WALK && !w_marker));

    // write port: push / checkpoint / commit append at the top
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = {5'd0, r_cmd.id, r_cmd.slot, r_cmd.prior};
        if (r_state == S_IDLE && i_valid && r_count < DEPTH_C) begin
            w_waddr = r_count[AW-1:0];
            case (i_cmd.op)
                OP_PUSH: begin
                    w_we    = 1'b1;
                    w_wdata = {1'b0, i_cmd.kind, i_cmd.id, i_cmd.slot, i_cmd.prior};
                end
                OP_CKPT: begin
                    w_we    = 1'b1;
                    w_wdata = {TAG_CKPT, i_cmd.id, i_cmd.slot, i_cmd.prior};
                end
                default: w_we = 1'b0;
            endcase
        end else if (r_state == S_SRCH && w_tag == TAG_CKPT && r_closed == '0
                     && r_cmd.op == OP_COMMIT && r_count < DEPTH_C) begin
            w_we    = 1'b1;
            w_wdata = {TAG_COMMIT, r_cmd.id, r_cmd.slot, r_cmd.prior};
        end
    end

    assign w_raddr = w_im1[AW-1:0];

    ujc_ram #(.WIDTH(REC_W), .DEPTH(JOURNAL_DEPTH)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // sequencer, journal count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_load) r_res_valid <= 1'b1;
            else if (i_res_pop && r_res_valid) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_idx    <= r_count;
                        r_closed <= '0;
                        case (i_cmd.op)
                            OP_PUSH, OP_CKPT: begin
                                r_state <= S_DONE;
                                if (r_count < DEPTH_C) begin
                                    r_count  <= r_count + 1'b1;
                                    r_status <= ST_OK;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_COMMIT, OP_REVERT: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NO_CKPT;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_SRCH_RD;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                // read address r_idx-1 is presented; data next cycle
                S_SRCH_RD: r_state <= S_SRCH;
                S_SRCH: begin
                    if (w_tag == TAG_COMMIT) begin
                        r_closed <= r_closed + 1'b1;
                    end else if (w_tag == TAG_CKPT) begin
                        if (r_closed == '0) begin
                            r_where <= w_im1;
                            if (r_cmd.op == OP_COMMIT) begin
                                if (r_count < DEPTH_C) r_count <= r_count + 1'b1;
                                else r_status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_count;
                                r_state <= S_WALK_RD;
                            end
                        end else begin
                            r_closed <= r_closed - 1'b1;
                        end
                    end
                    if (!(w_tag == TAG_CKPT && r_closed == '0)) begin
                        if (w_im1 == '0) begin
                            r_status <= ST_NO_CKPT;
                            r_state  <= S_DONE;
                        end else begin
                            r_idx   <= w_im1;
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_WALK_RD: begin
                    if (r_idx == r_where + 1'b1) begin
                        r_count <= r_where;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                // emit one record above the checkpoint, newest first; markers are skipped
                S_WALK: begin
                    if (w_marker) begin
                        r_idx   <= w_im1;
                        r_state <= S_WALK_RD;
                    end else if (w_slot_free) begin
                        r_res.status    <= ST_OK;
                        r_res.present   <= 1'b1;
                        r_res.kind      <= w_tag[3:0];
                        r_res.id        <= w_rdata[512 +: 32];
                        r_res.slot      <= w_rdata[256 +: 256];
                        r_res.prior_lo  <= w_rdata[0 +: 64];
                        r_res.prior_mid <= w_rdata[64 +: 64];
                        r_res.prior_hi  <= w_rdata[128 +: 64] ^ w_rdata[192 +: 64];
                        r_res.last      <= 1'b0;
                        r_idx           <= w_im1;
                        r_state         <= S_WALK_RD;
                    end
                end
                // done beat: status and last only, every other field zero
                S_DONE: begin
                    if (w_slot_free) begin
                        r_res   <= {r_status, {(RES_W-3){1'b0}}, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/undo_journal_checkpoints.sv
// ----------------------------------------------------------------------------
// undo_journal_checkpoints
// Undo journal with nested checkpoints; revert emits records newest first.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | push / full        | i_operation .. i_prior_word3
//  result  | empty / pop        | o_status .. o_last
//
// Push, checkpoint, clear: the engine passes S_DONE, which loads the done beat.
// Commit/revert: each journal entry scanned by the search passes S_SRCH_RD and S_SRCH, then
// each entry removed by the walk passes S_WALK_RD and S_WALK (one memory read port sets this).
// Reset clears the count and the control; memory contents are not cleared.
// A held result stalls the engine; the 2-entry input queue keeps filling.
module undo_journal_checkpoints #(
    parameter int JOURNAL_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    i_operation,
    input  logic [3:0]    i_record_kind,
    input  logic [31:0]   i_entity_id,
    input  logic [63:0]   i_slot_word0,
    input  logic [63:0]   i_slot_word1,
    input  logic [63:0]   i_slot_word2,
    input  logic [63:0]   i_slot_word3,
    input  logic [63:0]   i_prior_word0,
    input  logic [63:0]   i_prior_word1,
    input  logic [63:0]   i_prior_word2,
    input  logic [63:0]   i_prior_word3,
    output logic          empty,
    input  logic          pop,
    output logic [1:0]    o_status,
    output logic          o_undo_present,
    output logic [3:0]    o_undo_kind,
    output logic [31:0]   o_undo_id,
    output logic [63:0]   o_undo_slot0,
    output logic [63:0]   o_undo_slot1,
    output logic [63:0]   o_undo_slot2,
    output logic [63:0]   o_undo_slot3,
    output logic [63:0]   o_undo_prior_lo,
    output logic [63:0]   o_undo_prior_mid,
    output logic [63:0]   o_undo_prior_hi,
    output logic          o_last
);
    import ujc_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(JOURNAL_DEPTH + 1);

    t_cmd          w_in_cmd, w_q_cmd;
    t_res          w_res;
    logic          w_q_valid, w_take, w_res_valid;
    logic [CW-1:0] w_count;

    assign w_in_cmd = '{op: i_operation, kind: i_record_kind, id: i_entity_id,
        slot: {i_slot_word3, i_slot_word2, i_slot_word1, i_slot_word0},
        prior: {i_prior_word3, i_prior_word2, i_prior_word1, i_prior_word0}};

    ujc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_cmd(w_in_cmd),
        .o_valid(w_q_valid), .o_cmd(w_q_cmd), .i_take(w_take)
    );

    ujc_back #(.JOURNAL_DEPTH(JOURNAL_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .i_cmd(w_q_cmd), .o_take(w_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_pop(pop),
        .o_count(w_count)
    );

    // result ports
    assign empty            = !w_res_valid;
    assign o_status         = w_res.status;
    assign o_undo_present   = w_res.present;
    assign o_undo_kind      = w_res.kind;
    assign o_undo_id        = w_res.id;
    assign o_undo_slot0     = w_res.slot[63:0];
    assign o_undo_slot1     = w_res.slot[127:64];
    assign o_undo_slot2     = w_res.slot[191:128];
    assign o_undo_slot3     = w_res.slot[255:192];
    assign o_undo_prior_lo  = w_res.prior_lo;
    assign o_undo_prior_mid = w_res.prior_mid;
    assign o_undo_prior_hi  = w_res.prior_hi;
    assign o_last           = w_res.last;

    // checks
    `ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, w_count <= CW'(JOURNAL_DEPTH), "count over depth")
    `ASSERT_IMPL(a_last_clean, i_clk, i_rst_n, !empty && o_last, !o_undo_present, "done carries record")
    `ASSERT_IMPL(a_rec_ok, i_clk, i_rst_n, !empty && o_undo_present, o_status == ST_OK && !o_last, "bad record beat")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_last), "result dropped")
endmodule
